// ===== hdl/ssh_pkg.sv =====
// Package: selector codes, register map, hash state type and string restart values.
package ssh_pkg;

    localparam logic [2:0] ALG_BKDR = 3'd0;
    localparam logic [2:0] ALG_RS   = 3'd1;
    localparam logic [2:0] ALG_AP   = 3'd2;
    localparam logic [2:0] ALG_JS   = 3'd3;
    localparam logic [2:0] ALG_ELF  = 3'd4;

    localparam logic REG_ALGORITHM = 1'b0;

    localparam logic [31:0] BKDR_SEED      = 32'd131;
    localparam logic [31:0] RS_STEP        = 32'd378551;
    localparam logic [31:0] RS_START       = 32'd63689;
    localparam logic [31:0] JS_START       = 32'd1315423911;
    localparam logic [31:0] ELF_TOP_NIBBLE = 32'hF000_0000;
    localparam logic [31:0] OUT_MASK       = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [31:0] running_hash;
        logic [31:0] rs_multiplier;
        logic        odd_position;
    } hash_state_t;

    typedef struct packed {
        logic       restart;
        logic [2:0] algorithm_next;
    } cfg_ctrl_t;

    function automatic hash_state_t restart_state(input logic [2:0] alg);
        hash_state_t s;
        s.running_hash  = (alg == ALG_JS) ? JS_START : 32'd0;
        s.rs_multiplier = RS_START;
        s.odd_position  = 1'b0;
        return s;
    endfunction

endpackage

// ===== hdl/ssh_in_if.sv =====
// Interface: input byte channel.
interface ssh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

// ===== hdl/ssh_out_if.sv =====
// Interface: finished hash channel.
interface ssh_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

// ===== hdl/ssh_cfg_regs.sv =====
// Configuration registers: APB-style algorithm select register.
module ssh_cfg_regs
    import ssh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [2:0]  algorithm,
    output cfg_ctrl_t   ctrl
);

    logic [2:0] algorithm_reg;
    logic       write_hit;

    assign pready    = 1'b1;
    assign write_hit = psel && penable && pwrite && (paddr[2] == REG_ALGORITHM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            algorithm_reg <= ALG_BKDR;
        end
        else if (write_hit)
        begin
            algorithm_reg <= pwdata[2:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_ALGORITHM)
        begin
            prdata = {29'd0, algorithm_reg};
        end
        else
        begin
            prdata = 32'd0;
        end
    end

    assign algorithm           = algorithm_reg;
    assign ctrl.restart        = write_hit;
    assign ctrl.algorithm_next = pwdata[2:0];

endmodule

// ===== hdl/ssh_fold.sv =====
// Fold unit: folds one sign-extended byte into the running hash state.
module ssh_fold
    import ssh_pkg::*;
(
    input  logic [2:0]  algorithm,
    input  hash_state_t state_cur,
    input  logic [7:0]  byte_value,
    output hash_state_t state_new
);

    logic [31:0] c;
    logic [31:0] h;
    logic [31:0] h_elf;
    logic [31:0] top;

    assign c = {{24{byte_value[7]}}, byte_value};
    assign h = state_cur.running_hash;

    always_comb
    begin
        state_new              = state_cur;
        state_new.odd_position = ~state_cur.odd_position;
        h_elf                  = (h << 4) + c;
        top                    = h_elf & ELF_TOP_NIBBLE;
        case (algorithm)
            ALG_RS:
            begin
                state_new.running_hash  = h * state_cur.rs_multiplier + c;
                state_new.rs_multiplier = state_cur.rs_multiplier * RS_STEP;
            end
            ALG_AP:
            begin
                if (!state_cur.odd_position)
                begin
                    state_new.running_hash = h ^ ((h << 7) ^ c ^ (h >> 3));
                end
                else
                begin
                    state_new.running_hash = h ^ ~((h << 11) ^ c ^ (h >> 5));
                end
            end
            ALG_JS:
            begin
                state_new.running_hash = h ^ ((h << 5) + c + (h >> 2));
            end
            ALG_ELF:
            begin
                if (top != 32'd0)
                begin
                    state_new.running_hash = (h_elf ^ (top >> 24)) & ~top;
                end
                else
                begin
                    state_new.running_hash = h_elf;
                end
            end
            default:
            begin
                state_new.running_hash = h * BKDR_SEED + c;
            end
        endcase
    end

endmodule

// ===== hdl/selectable_string_hash.sv =====
// Top level: selectable string hash, 32-bit state, 31-bit result, one byte per word.
// Timing: a byte is registered on acceptance and folded from the input register;
//   the hash of a last byte is folded straight into the output register.
// Throughput: one byte per cycle unless a last byte waits; the fold is combinational.
// A last byte waits in the input register only while the previous hash is untaken.
// Reset: asynchronous, active low; algorithm BKDR, state at its string restart values.
module selectable_string_hash
    import ssh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ssh_in_if.sink       str_in,
    ssh_out_if.source    hash_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [2:0]  algorithm;
    cfg_ctrl_t   cfg_ctrl;

    logic        a_valid_reg;
    logic [7:0]  a_byte_reg;
    logic        a_last_reg;
    hash_state_t state_reg;
    hash_state_t state_new;
    logic        o_valid_reg;
    logic [30:0] o_hash_reg;

    logic        out_free;
    logic        fire;
    logic        in_take;

    ssh_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .algorithm (algorithm),
        .ctrl      (cfg_ctrl)
    );

    ssh_fold u_fold (
        .algorithm  (algorithm),
        .state_cur  (state_reg),
        .byte_value (a_byte_reg),
        .state_new  (state_new)
    );

    assign out_free     = !o_valid_reg || hash_out.ready;
    assign fire         = a_valid_reg && (!a_last_reg || out_free);
    assign str_in.ready = !a_valid_reg || fire;
    assign in_take      = str_in.valid && str_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (str_in.ready)
        begin
            a_valid_reg <= str_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_byte_reg <= str_in.byte_value;
            a_last_reg <= str_in.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= restart_state(ALG_BKDR);
        end
        else if (cfg_ctrl.restart)
        begin
            state_reg <= restart_state(cfg_ctrl.algorithm_next);
        end
        else if (fire)
        begin
            if (a_last_reg)
            begin
                state_reg <= restart_state(algorithm);
            end
            else
            begin
                state_reg <= state_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (fire && a_last_reg)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (hash_out.ready)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && a_last_reg)
        begin
            o_hash_reg <= state_new.running_hash[30:0] & OUT_MASK[30:0];
        end
    end

    assign hash_out.valid      = o_valid_reg;
    assign hash_out.hash_value = o_hash_reg;

    a_last_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && a_last_reg && !out_free) |=> (a_valid_reg && a_last_reg))
        else $error("stalled last byte lost from input register");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && a_last_reg) |=> o_valid_reg)
        else $error("last byte folded without a result");

    a_string_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        ((fire && a_last_reg) || cfg_ctrl.restart)
            |=> (!state_reg.odd_position && state_reg.rs_multiplier == RS_START))
        else $error("state not restarted after end of string or register write");

endmodule

// ===== tb/ssh_hash_checker.sv =====
`timescale 1ns / 1ps
// Checker: predicts each string hash from the observed bytes and register writes, and compares.
module ssh_hash_checker
    import ssh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ssh_in_if           str_mon,
    ssh_out_if          hash_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          failures,
    output int          hashes_checked,
    output int          hashes_pending
);

    localparam int REPORT_LIMIT = 10;

    logic [2:0]  alg_sel;
    logic [31:0] acc_hash;
    logic [31:0] acc_mult;
    logic        acc_odd;
    logic [30:0] pending_hashes[$];
    int          err_count;
    int          seen_count;

    initial
    begin
        failures       = 0;
        hashes_checked = 0;
        hashes_pending = 0;
        err_count      = 0;
        seen_count     = 0;
    end

    task automatic reseed_hash();
        acc_hash = (alg_sel == ALG_JS) ? JS_START : 32'd0;
        acc_mult = RS_START;
        acc_odd  = 1'b0;
    endtask

    task automatic absorb_char(input logic [7:0] b);
        logic [31:0] c;
        logic [31:0] h;
        logic [31:0] top;
        c = {{24{b[7]}}, b};
        h = acc_hash;
        case (alg_sel)
            ALG_RS:
            begin
                h        = h * acc_mult + c;
                acc_mult = acc_mult * RS_STEP;
            end
            ALG_AP:
            begin
                if (!acc_odd)
                    h = h ^ ((h << 7) ^ c ^ (h >> 3));
                else
                    h = h ^ ~((h << 11) ^ c ^ (h >> 5));
            end
            ALG_JS:
                h = h ^ ((h << 5) + c + (h >> 2));
            ALG_ELF:
            begin
                h   = (h << 4) + c;
                top = h & ELF_TOP_NIBBLE;
                if (top != 32'd0)
                begin
                    h = h ^ (top >> 24);
                    h = h & ~top;
                end
            end
            default:
                h = h * BKDR_SEED + c;
        endcase
        acc_hash = h;
        acc_odd  = ~acc_odd;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [30:0] want;
        if (!rst_n)
        begin
            alg_sel = ALG_BKDR;
            reseed_hash();
            pending_hashes.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_ALGORITHM)
            begin
                alg_sel = pwdata[2:0];
                reseed_hash();
            end
            if (str_mon.valid && str_mon.ready)
            begin
                absorb_char(str_mon.byte_value);
                if (str_mon.last_byte)
                begin
                    pending_hashes.push_back(acc_hash[30:0] & OUT_MASK[30:0]);
                    reseed_hash();
                end
            end
            if (hash_mon.valid && hash_mon.ready)
            begin
                seen_count++;
                if (pending_hashes.size() == 0)
                begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT)
                        $display("hash %h arrived with nothing pending", hash_mon.hash_value);
                end
                else
                begin
                    want = pending_hashes.pop_front();
                    if (hash_mon.hash_value !== want)
                    begin
                        err_count++;
                        if (err_count <= REPORT_LIMIT)
                            $display("hash mismatch: expected %h, actual %h",
                                     want, hash_mon.hash_value);
                    end
                end
            end
            failures       <= err_count;
            hashes_checked <= seen_count;
            hashes_pending <= pending_hashes.size();
        end
    end

endmodule

// ===== tb/tb_selectable_string_hash.sv =====
`timescale 1ns / 1ps
// Testbench top: drives strings and algorithm writes into the hash block and gives the verdict.
module tb_selectable_string_hash;
    import ssh_pkg::*;

    localparam int          PHASE_BYTES   = 267;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          HOLD_CYCLES   = 160;
    localparam int          ALG_CODE_MAX  = 7;
    localparam logic [2:0]  ALGORITHM_ADDR = {REG_ALGORITHM, 2'b00};
    localparam logic [2:0]  UNMAPPED_ADDR  = 3'd4;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int failures;
    int hashes_checked;
    int hashes_pending;
    int send_idle_pct;
    int recv_idle_pct;
    int bytes_sent;
    int reg_writes;
    int hold_requests;
    int holds_served;
    int hold_left;
    int cycle_count;

    logic [2:0] directed_algs [3] = '{ALG_RS, ALG_AP, ALG_JS};

    ssh_in_if  str_in();
    ssh_out_if hash_out();

    selectable_string_hash u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .str_in   (str_in),
        .hash_out (hash_out),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ssh_hash_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .str_mon        (str_in),
        .hash_mon       (hash_out),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .failures       (failures),
        .hashes_checked (hashes_checked),
        .hashes_pending (hashes_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            hash_out.ready <= 1'b0;
        end
        else
            hash_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic terminate);
        while ($urandom_range(99) < send_idle_pct)
        begin
            str_in.valid <= 1'b0;
            @(posedge clk);
        end
        str_in.valid      <= 1'b1;
        str_in.byte_value <= b;
        str_in.last_byte  <= terminate;
        @(posedge clk);
        while (!str_in.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_string(input int len, input logic terminate);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), terminate && (i == len - 1));
    endtask

    // drop valid and wait out every pending hash plus the fold pipeline
    task automatic settle();
        str_in.valid <= 1'b0;
        @(posedge clk);
        while (hashes_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        int          goal;
        int          n_strings;
        logic [31:0] data;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        goal = bytes_sent + PHASE_BYTES;
        settle();
        hold_requests++;
        for (int i = 0; i < 24; i++)
            send_string($urandom_range(1, 2), 1'b1);
        while (bytes_sent < goal)
        begin
            settle();
            if ($urandom_range(5) == 0)
                apb_write(UNMAPPED_ADDR, $urandom);
            data = $urandom;
            if ($urandom_range(3) != 0)
                data[31:3] = '0;
            apb_write(ALGORITHM_ADDR, data);
            n_strings = $urandom_range(3, 10);
            for (int i = 0; i < n_strings; i++)
                send_string(($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 8), 1'b1);
            if ($urandom_range(3) == 0)
                send_string($urandom_range(1, 5), 1'b0);
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        str_in.valid      = 1'b0;
        str_in.byte_value = '0;
        str_in.last_byte  = 1'b0;
        hash_out.ready    = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        bytes_sent        = 0;
        reg_writes        = 0;
        hold_requests     = 0;
        holds_served      = 0;
        hold_left         = 0;
        cycle_count       = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        foreach (directed_algs[i])
        begin
            settle();
            apb_write(ALGORITHM_ADDR, 32'(directed_algs[i]));
            send_byte(8'h7F, 1'b0);
            send_byte(8'h80, 1'b1);
        end
        settle();
        apb_write(ALGORITHM_ADDR, 32'hFFFF_FFF8 | 32'(ALG_ELF));
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b1);
        for (int v = ALG_ELF + 1; v <= ALG_CODE_MAX; v++)
        begin
            settle();
            apb_write(ALGORITHM_ADDR, 32'(v));
            send_byte(8'hA5, 1'b1);
        end
        settle();
        apb_write(UNMAPPED_ADDR, 32'(ALG_JS));
        send_byte(8'h5A, 1'b1);
        settle();
        apb_write(ALGORITHM_ADDR, 32'(ALG_JS));
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        settle();
        apb_write(ALGORITHM_ADDR, 32'(ALG_AP));
        send_byte(8'h43, 1'b1);

        run_phase(28, 78);
        run_phase(78, 28);
        run_phase(0, 0);
        settle();

        $display("Sent %0d bytes, checked %0d hashes, made %0d register writes.",
                 bytes_sent, hashes_checked, reg_writes);
        $display("Covered all selector codes, unmapped writes, dropped partial strings, hold-offs.");
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ssh_pkg.sv
hdl/ssh_in_if.sv
hdl/ssh_out_if.sv
hdl/ssh_cfg_regs.sv
hdl/ssh_fold.sv
hdl/selectable_string_hash.sv
tb/ssh_hash_checker.sv
tb/tb_selectable_string_hash.sv
